// File: src/contiguous_extent_allocator_macros.svh
// Assertion macros used by the allocator port checker
`ifndef CONTIGUOUS_EXTENT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_EXTENT_ALLOCATOR_MACROS_SVH

// Check that a condition implies another in the same cycle
`define CEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define CEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cea_pkg.sv
// Types and constants of the contiguous extent allocator
package cea_pkg;

  // map digit: blocks handled per map word
  localparam int DIG_W  = 8;
  localparam int DIG_LG = 3;

  // field widths
  localparam int OP_W    = 2;
  localparam int START_W = 12;
  localparam int CNT_W   = 13;
  localparam int STAT_W  = 2;
  localparam int TB_W    = 13;
  localparam int FSS_W   = 12;
  localparam int CFG_IDX_W = 1;

  // last metadata block; search starts just past it after reset
  localparam logic [FSS_W-1:0] META_LAST_BLOCK = 12'd11;
  localparam logic [FSS_W-1:0] FSS_RESET       = META_LAST_BLOCK + 12'd1;
  localparam logic [TB_W-1:0]  TB_RESET        = 13'd4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START  = 1'b1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

// File: src/cea_ram.sv
// Generic simple dual-port RAM with registered read
module cea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/contiguous_extent_allocator.sv
// Contiguous extent allocator: first-fit search and range update over a block bitmap
//
//   channel  | signals                                     | handshake
//   ---------+---------------------------------------------+-------------------
//   in       | in_op, in_range_start, in_block_count       | in_valid/in_ready
//   out      | out_status, out_run_start                   | out_valid/out_ready
//   cfg      | cfg_index, cfg_data                         | cfg_wr_en, no wait
//
// Map: RAM of MAX_BLOCKS/8 words, 8 blocks per word, one word read a cycle.
// Free/reserve: a check step, then a fill pass over each map word the range touches.
// Allocate: a check step, a scan of the words up to the end of the fitting run, then
// a marking pass over the words of that run; no fit: a check step and the words scanned.
// After reset a clearing pass over all MAX_BLOCKS/8 map words holds in_ready low.
// A result waiting on out_ready lets the next item be taken, but holds it in ST_DONE.
module contiguous_extent_allocator #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cea_pkg::OP_W-1:0]             in_op,
  input  logic [cea_pkg::START_W-1:0]          in_range_start,
  input  logic [cea_pkg::CNT_W-1:0]            in_block_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cea_pkg::STAT_W-1:0]           out_status,
  output logic [cea_pkg::START_W-1:0]          out_run_start,
  input  logic                                 cfg_wr_en,
  input  logic [cea_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cea_pkg::TB_W-1:0]             cfg_data
);

  localparam int DW  = cea_pkg::DIG_W;
  localparam int DL  = cea_pkg::DIG_LG;
  localparam int NW  = MAX_BLOCKS / DW;
  localparam int WA  = $clog2(NW);
  localparam int BKW = WA + DL;
  localparam int VW  = $clog2(MAX_BLOCKS + 1);
  localparam int CW0 = (VW > BKW + 1) ? VW : BKW + 1;
  localparam int CW  = (CW0 > 14) ? CW0 : 14;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

  // configuration registers
  logic [cea_pkg::TB_W-1:0]  tb_r;
  logic [cea_pkg::FSS_W-1:0] fss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r  <= cea_pkg::TB_RESET;
      fss_r <= cea_pkg::FSS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cea_pkg::CFG_TOTAL_BLOCKS: tb_r  <= cfg_data;
        cea_pkg::CFG_FIRST_START:  fss_r <= cfg_data[cea_pkg::FSS_W-1:0];
        default: ;
      endcase
    end
  end

  // volume size clipped to the map capacity
  logic [CW-1:0] tb_ext, fss_ext, vol;
  assign tb_ext  = CW'(tb_r);
  assign fss_ext = CW'(fss_r);
  assign vol     = (tb_ext > MAXC) ? MAXC : tb_ext;

  // control and item registers
  cea_pkg::state_t state_r, state_nxt;
  logic [WA-1:0]   clr_addr_r, clr_addr_nxt;
  logic [cea_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [cea_pkg::START_W-1:0] rstart_r, rstart_nxt;
  logic [cea_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [WA-1:0]   scan_addr_r, scan_addr_nxt;
  logic [WA-1:0]   last_word_r, last_word_nxt;
  logic            issue_done_r, issue_done_nxt;
  logic            pv_r, pv_nxt;
  logic [WA-1:0]   paddr_r, paddr_nxt;
  logic [CW-1:0]   run_r, run_nxt;
  logic [CW-1:0]   fstart_r, fstart_nxt;
  logic [CW-1:0]   fend_r, fend_nxt;
  logic            fval_r, fval_nxt;
  cea_pkg::stat_t  res_stat_r, res_stat_nxt;
  logic [cea_pkg::START_W-1:0] res_ext_r, res_ext_nxt;
  logic            out_valid_r, out_valid_nxt;
  cea_pkg::stat_t  out_stat_r, out_stat_nxt;
  logic [cea_pkg::START_W-1:0] out_ext_r, out_ext_nxt;

  // map RAM
  logic          ram_we;
  logic [WA-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  cea_ram #(
    .WIDTH (DW),
    .DEPTH (NW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  // evaluate the word in hand: run lengths for the search, merged bits for the fill
  logic [CW-1:0] need;
  logic [CW-1:0] blk_v [DW];
  logic [CW-1:0] run_v [DW];
  logic [DW-1:0] used_v, found_v, fill_word;
  logic          has_used, hit;
  int            last_used;
  logic [DL-1:0] hit_j;
  logic [CW-1:0] hit_blk, fend_found, fstart_found;

  assign need = CW'(count_r);

  always_comb begin
    for (int j = 0; j < DW; j++) begin
      blk_v[j]  = CW'({paddr_r, DL'(j)});
      used_v[j] = ram_rdata[j] || (blk_v[j] < fss_ext) || (blk_v[j] >= vol);
      fill_word[j] = ((blk_v[j] >= fstart_r) && (blk_v[j] < fend_r)) ? fval_r : ram_rdata[j];
    end
    has_used  = 1'b0;
    last_used = 0;
    for (int j = 0; j < DW; j++) begin
      has_used  = 1'b0;
      last_used = 0;
      for (int k = 0; k < DW; k++) begin
        if (k <= j && used_v[k]) begin
          has_used  = 1'b1;
          last_used = k;
        end
      end
      run_v[j]   = has_used ? CW'(j - last_used) : run_r + CW'(j + 1);
      found_v[j] = !used_v[j] && (run_v[j] == need);
    end
    hit   = |found_v;
    hit_j = '0;
    for (int j = DW - 1; j >= 0; j--) begin
      if (found_v[j]) begin
        hit_j = DL'(j);
      end
    end
    hit_blk      = blk_v[hit_j];
    fend_found   = hit_blk + CW'(1);
    fstart_found = fend_found - need;
  end

  // checks on the accepted item
  logic [CW-1:0] range_end, range_last, vol_last;
  assign range_end  = CW'(rstart_r) + CW'(count_r);
  assign range_last = range_end - CW'(1);
  assign vol_last   = vol - CW'(1);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cea_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    rstart_r     <= rstart_nxt;
    count_r      <= count_nxt;
    scan_addr_r  <= scan_addr_nxt;
    last_word_r  <= last_word_nxt;
    issue_done_r <= issue_done_nxt;
    paddr_r      <= paddr_nxt;
    run_r        <= run_nxt;
    fstart_r     <= fstart_nxt;
    fend_r       <= fend_nxt;
    fval_r       <= fval_nxt;
    res_stat_r   <= res_stat_nxt;
    res_ext_r    <= res_ext_nxt;
    out_stat_r   <= out_stat_nxt;
    out_ext_r    <= out_ext_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    rstart_nxt     = rstart_r;
    count_nxt      = count_r;
    scan_addr_nxt  = scan_addr_r;
    last_word_nxt  = last_word_r;
    issue_done_nxt = issue_done_r;
    pv_nxt         = 1'b0;
    paddr_nxt      = paddr_r;
    run_nxt        = run_r;
    fstart_nxt     = fstart_r;
    fend_nxt       = fend_r;
    fval_nxt       = fval_r;
    res_stat_nxt   = res_stat_r;
    res_ext_nxt    = res_ext_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_stat_nxt   = out_stat_r;
    out_ext_nxt    = out_ext_r;
    ram_we         = 1'b0;
    ram_waddr      = paddr_r;
    ram_wdata      = fill_word;
    in_ready       = 1'b0;

    // stream reads: one map word issued per cycle while scanning or filling
    if ((state_r == cea_pkg::ST_SEARCH || state_r == cea_pkg::ST_FILL) && !issue_done_r) begin
      scan_addr_nxt  = scan_addr_r + WA'(1);
      pv_nxt         = 1'b1;
      paddr_nxt      = scan_addr_r;
      issue_done_nxt = (scan_addr_r == last_word_r);
    end

    case (state_r)
      cea_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + WA'(1);
        if (clr_addr_r == WA'(NW - 1)) begin
          state_nxt = cea_pkg::ST_IDLE;
        end
      end

      cea_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_op;
          rstart_nxt = in_range_start;
          count_nxt  = in_block_count;
          state_nxt  = cea_pkg::ST_CHECK;
        end
      end

      cea_pkg::ST_CHECK: begin
        res_ext_nxt    = '0;
        res_stat_nxt   = cea_pkg::STAT_OK;
        issue_done_nxt = 1'b0;
        run_nxt        = '0;
        state_nxt      = cea_pkg::ST_DONE;
        case (op_r)
          cea_pkg::OP_ALLOC: begin
            if (count_r == '0) begin
              res_stat_nxt = cea_pkg::STAT_EMPTY;
            end else if (fss_ext >= vol) begin
              res_stat_nxt = cea_pkg::STAT_NOFIT;
            end else begin
              scan_addr_nxt = fss_ext[DL +: WA];
              last_word_nxt = vol_last[DL +: WA];
              state_nxt     = cea_pkg::ST_SEARCH;
            end
          end
          cea_pkg::OP_FREE, cea_pkg::OP_RESERVE: begin
            if (count_r == '0) begin
              res_stat_nxt = cea_pkg::STAT_EMPTY;
            end else if (range_end > vol) begin
              res_stat_nxt = cea_pkg::STAT_RANGE;
            end else begin
              fstart_nxt    = CW'(rstart_r);
              fend_nxt      = range_end;
              fval_nxt      = (op_r == cea_pkg::OP_RESERVE);
              scan_addr_nxt = rstart_r[DL +: (cea_pkg::START_W - DL)] == '0 ?
                              WA'(0) : WA'(rstart_r >> DL);
              last_word_nxt = range_last[DL +: WA];
              state_nxt     = cea_pkg::ST_FILL;
            end
          end
          default: ;
        endcase
      end

      cea_pkg::ST_SEARCH: begin
        if (pv_r) begin
          if (hit) begin
            // mark the run found: restart the stream over its words
            fstart_nxt     = fstart_found;
            fend_nxt       = fend_found;
            fval_nxt       = 1'b1;
            res_ext_nxt    = fstart_found[cea_pkg::START_W-1:0];
            scan_addr_nxt  = fstart_found[DL +: WA];
            last_word_nxt  = paddr_r;
            issue_done_nxt = 1'b0;
            pv_nxt         = 1'b0;
            state_nxt      = cea_pkg::ST_FILL;
          end else if (paddr_r == last_word_r) begin
            res_stat_nxt = cea_pkg::STAT_NOFIT;
            pv_nxt       = 1'b0;
            state_nxt    = cea_pkg::ST_DONE;
          end else begin
            run_nxt = run_v[DW-1];
          end
        end
      end

      cea_pkg::ST_FILL: begin
        if (pv_r) begin
          ram_we = 1'b1;
          if (paddr_r == last_word_r) begin
            state_nxt = cea_pkg::ST_DONE;
          end
        end
      end

      cea_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_ext_nxt   = res_ext_r;
          state_nxt     = cea_pkg::ST_IDLE;
        end
      end

      default: state_nxt = cea_pkg::ST_IDLE;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_stat_r;
  assign out_run_start = out_ext_r;

endmodule

// File: src/cea_chk.sv
// Port checker for the contiguous extent allocator, bound to the top level
`include "contiguous_extent_allocator_macros.svh"

module cea_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cea_pkg::STAT_W-1:0]      out_status,
  input logic [cea_pkg::START_W-1:0]     out_run_start
);

  // stalled result and its payload as one word
  logic                                      out_stall;
  logic [cea_pkg::STAT_W+cea_pkg::START_W-1:0] out_word;
  logic                                      start_set;

  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_status, out_run_start};
  assign start_set = out_valid && (out_run_start != '0);

  // hold a stalled result
  `CEA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")

  // a nonzero start only comes with a successful allocation
  `CEA_ASSERT_NOW(a_start_ok, start_set, out_status == cea_pkg::STAT_OK, "start without ok status")

  // one item at a time: ready drops after an item is taken
  `CEA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

  // map clearing pass follows reset
  `CEA_ASSERT_NOW(a_clear_after_reset, $rose(rst_n), !in_ready, "item taken before map clear")

endmodule

bind contiguous_extent_allocator cea_chk u_cea_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_run_start    (out_run_start)
);

// File: verif/cea_checker.sv
// Result checker for the contiguous extent allocator: block map predictor and comparison
module cea_checker #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [cea_pkg::OP_W-1:0]      in_op,
  input  logic [cea_pkg::START_W-1:0]   in_range_start,
  input  logic [cea_pkg::CNT_W-1:0]     in_block_count,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [cea_pkg::STAT_W-1:0]    out_status,
  input  logic [cea_pkg::START_W-1:0]   out_run_start,
  input  logic                          cfg_wr_en,
  input  logic [cea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cea_pkg::TB_W-1:0]      cfg_data,
  output int                            failures,
  output int                            results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import cea_pkg::*;

  typedef struct packed {
    stat_t               status;
    logic [START_W-1:0]  run_start;
  } outcome_t;

  // mirror of the allocation map and the two registers
  logic             block_used [MAX_BLOCKS];
  logic [TB_W-1:0]  volume_reg;
  logic [FSS_W-1:0] search_from;
  outcome_t         pending_outcomes [$];

  // set or clear a run of blocks, dropping anything past the map
  function automatic void mark_range(input int first, input int count, input logic val);
    for (int b = first; b < first + count; b++) begin
      if (b < MAX_BLOCKS) block_used[b] = val;
    end
  endfunction

  // update the map for one request and work out its result
  function automatic outcome_t apply_request(input logic [OP_W-1:0] op,
                                             input logic [START_W-1:0] first,
                                             input logic [CNT_W-1:0] count);
    outcome_t res;
    int       vol;
    int       run;
    int       need;
    res.status    = STAT_OK;
    res.run_start = '0;
    vol  = (int'(volume_reg) > MAX_BLOCKS) ? MAX_BLOCKS : int'(volume_reg);
    need = int'(count);
    run  = 0;
    // unused op code: plain ok, map untouched
    if (op != OP_ALLOC && op != OP_FREE && op != OP_RESERVE) return res;
    if (need == 0) begin
      res.status = STAT_EMPTY;
      return res;
    end
    if (op == OP_ALLOC) begin
      // first fit from the search start upward
      res.status = STAT_NOFIT;
      for (int b = int'(search_from); b < vol; b++) begin
        run = block_used[b] ? 0 : run + 1;
        if (run == need) begin
          res.status    = STAT_OK;
          res.run_start = START_W'(b + 1 - need);
          mark_range(b + 1 - need, need, 1'b1);
          break;
        end
      end
    end else if (int'(first) + need > vol) begin
      res.status = STAT_RANGE;
    end else begin
      mark_range(int'(first), need, op == OP_RESERVE);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      foreach (block_used[b]) block_used[b] = 1'b0;
      volume_reg   = TB_RESET;
      search_from  = FSS_RESET;
      pending_outcomes.delete();
      failures     = 0;
      results_seen = 0;
    end else begin
      // compare the result with the oldest prediction
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          failures++;
          $display("%0t: result with no item waiting, status %0d run start %0d",
                   $time, out_status, out_run_start);
        end else begin
          want = pending_outcomes.pop_front();
          if (out_status !== want.status) begin
            failures++;
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, out_status);
          end
          if (out_run_start !== want.run_start) begin
            failures++;
            $display("%0t: run start mismatch, expected %0d got %0d",
                     $time, want.run_start, out_run_start);
          end
        end
      end
      // register writes
      if (cfg_wr_en) begin
        if (cfg_index == CFG_TOTAL_BLOCKS) volume_reg = cfg_data;
        else if (cfg_index == CFG_FIRST_START) search_from = cfg_data[FSS_W-1:0];
      end
      // predict each accepted item
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(apply_request(in_op, in_range_start, in_block_count));
      end
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the allocator testbench: clock, reset, stimulus, result stalls and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cea_pkg::*;

  localparam int MAX_BLOCKS  = 4096;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic [OP_W-1:0]      in_op            = '0;
  logic [START_W-1:0]   in_range_start   = '0;
  logic [CNT_W-1:0]     in_block_count   = '0;
  logic                 out_ready        = 1'b0;
  logic                 cfg_wr_en        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [TB_W-1:0]      cfg_data         = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic [STAT_W-1:0]    out_status;
  logic [START_W-1:0]   out_run_start;

  int failures;
  int results_seen;
  int items_sent  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  // volume size, search start and item count of each random phase
  int phase_total [7] = '{4096, 13, 8191, 600, 4096, 200, 5000};
  int phase_first [7] = '{12, 0, 0, 12, 4095, 100, 3000};
  int phase_items [7] = '{180, 100, 150, 170, 60, 150, 90};

  contiguous_extent_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_range_start   (in_range_start),
    .in_block_count   (in_block_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_run_start    (out_run_start),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cea_checker #(.MAX_BLOCKS(MAX_BLOCKS)) allocation_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_range_start   (in_range_start),
    .in_block_count   (in_block_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_run_start    (out_run_start),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .failures         (failures),
    .results_seen     (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL contiguous_extent_allocator");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // offer one item, hold it until accepted, then maybe idle
  task automatic send_item(input logic [OP_W-1:0] op, input int first, input int count);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_range_start <= START_W'(first);
    in_block_count <= CNT_W'(count);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    wait (results_seen == items_sent);
    repeat (8) @(posedge clk);
  endtask

  // write both registers on back-to-back cycles
  task automatic write_regs(input int total, input int first);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TOTAL_BLOCKS;
    cfg_data  <= TB_W'(total);
    @(posedge clk);
    cfg_index <= CFG_FIRST_START;
    cfg_data  <= TB_W'(first);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly allocations and in-volume frees near the search area, some noise
  task automatic random_request(input int vol, input int base);
    int pick;
    int lo;
    int hi;
    int first;
    int count;
    pick  = $urandom_range(99);
    lo    = (base < vol) ? base : 0;
    hi    = (lo + 400 < vol) ? lo + 400 : vol - 1;
    first = $urandom_range(hi, lo);
    if ($urandom_range(9) == 0) count = $urandom_range(vol - first + 4, 1);
    else count = $urandom_range((vol - first < 64) ? vol - first : 64, 1);
    if (pick < 45) begin
      pick = $urandom_range(99);
      if (pick < 80) count = $urandom_range(16, 1);
      else if (pick < 95) count = $urandom_range(200, 17);
      else count = $urandom_range(vol + 8, 1);
      send_item(OP_ALLOC, $urandom_range(4095), count);
    end else if (pick < 75) begin
      send_item(OP_FREE, first, count);
    end else if (pick < 85) begin
      send_item(OP_RESERVE, first, count);
    end else if (pick < 93) begin
      send_item(OP_W'($urandom_range(3)), $urandom_range(4095), $urandom_range(4096));
    end else begin
      send_item(OP_W'($urandom_range(3)), $urandom_range(4095), 0);
    end
  endtask

  initial begin
    int vol;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty requests, unused op code, extremes at the reset settings
    send_item(OP_ALLOC, 4095, 0);
    send_item(OP_FREE, 0, 0);
    send_item(OP_RESERVE, 4095, 0);
    send_item(OP_UNUSED, 4095, 4096);
    send_item(OP_ALLOC, 0, 1);
    send_item(OP_ALLOC, 0, 4096);
    send_item(OP_ALLOC, 0, 4084);
    send_item(OP_ALLOC, 4095, 4083);
    send_item(OP_FREE, 0, 4096);
    send_item(OP_FREE, 4095, 2);
    send_item(OP_RESERVE, 4095, 1);
    send_item(OP_RESERVE, 0, 12);
    send_item(OP_ALLOC, 0, 4084);
    send_item(OP_ALLOC, 0, 4083);
    send_item(OP_FREE, 100, 200);
    send_item(OP_ALLOC, 0, 150);
    send_item(OP_RESERVE, 4095, 4096);
    send_item(OP_FREE, 0, 4096);

    // smallest volume, search from block zero
    drain();
    write_regs(13, 0);
    send_item(OP_ALLOC, 0, 13);
    send_item(OP_ALLOC, 0, 1);
    send_item(OP_FREE, 0, 13);
    send_item(OP_RESERVE, 0, 14);

    // search start past the end of the volume
    drain();
    write_regs(13, 4095);
    send_item(OP_ALLOC, 0, 1);

    // random phases, each from an empty map
    for (int p = 0; p < 7; p++) begin
      drain();
      quiet = (p == 2);
      write_regs(phase_total[p], phase_first[p]);
      vol = (phase_total[p] > MAX_BLOCKS) ? MAX_BLOCKS : phase_total[p];
      send_item(OP_FREE, 0, vol);
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 0 && n == 20) hold_req = 1'b1;
        if (n % 60 == 59) send_item(OP_FREE, 0, vol);
        else random_request(vol, phase_first[p]);
      end
    end

    drain();
    if (failures == 0) begin
      $display("PASS contiguous_extent_allocator");
    end else begin
      $display("FAIL contiguous_extent_allocator");
    end
    $finish;
  end

endmodule
